// ===== sv/lru_key_value_cache_top_macros.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define LKVC_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== sv/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

   localparam int MODE_W  = 2;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 32;
   localparam int ITEM_W  = 7;
   localparam int CAP_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_TOUCH  = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic        probe;
      cell_op_type op;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== sv/lkvc_req_if.sv =====
// Request channel interface: operation, key and write value.
`default_nettype none

interface lkvc_req_if;
   logic                          valid;
   logic                          ready;
   logic [lkvc_pkg::MODE_W-1:0]   mode;
   logic [lkvc_pkg::KEY_W-1:0]    key;
   logic [lkvc_pkg::VALUE_W-1:0]  write_value;

   modport source (output valid, output mode, output key, output write_value, input ready);
   modport sink   (input valid, input mode, input key, input write_value, output ready);
endinterface

`default_nettype wire

// ===== sv/lkvc_rsp_if.sv =====
// Response channel interface: status, read value and counters.
`default_nettype none

interface lkvc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [lkvc_pkg::VALUE_W-1:0]  read_value;
   logic [lkvc_pkg::COUNT_W-1:0]  hit_count;
   logic [lkvc_pkg::COUNT_W-1:0]  miss_count;
   logic [lkvc_pkg::ITEM_W-1:0]   item_count;

   modport source (output valid, output status, output read_value, output hit_count,
                   output miss_count, output item_count, input ready);
   modport sink   (input valid, input status, input read_value, input hit_count,
                   input miss_count, input item_count, output ready);
endinterface

`default_nettype wire

// ===== sv/lkvc_cell.sv =====
// One recency-ordered entry cell of the cache chain.
`default_nettype none

module lkvc_cell #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int CNT_W      = 7,
   parameter int IDX        = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire lkvc_pkg::cell_cmd_type cmd,
   input  wire  [KEY_BITS-1:0]       probe_key,
   input  wire  [CNT_W-1:0]          limit,
   input  wire                       above_in,
   input  wire                       prev_valid,
   input  wire  [KEY_BITS-1:0]       prev_key,
   input  wire  [VALUE_BITS-1:0]     prev_value,
   input  wire                       next_valid,
   input  wire  [KEY_BITS-1:0]       next_key,
   input  wire  [VALUE_BITS-1:0]     next_value,
   output logic                      valid,
   output logic [KEY_BITS-1:0]       key,
   output logic [VALUE_BITS-1:0]     value,
   output logic                      match,
   output logic                      above_out,
   output logic [VALUE_BITS-1:0]     sel_value
);

   logic                  valid_ff, valid_in;
   logic                  match_ff, match_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  shift;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      shift    = above_in | match_ff;
      unique case (cmd.op)
         lkvc_pkg::OP_HOLD: begin
         end
         lkvc_pkg::OP_TOUCH: begin
            if (!above_in) begin
               valid_in = prev_valid;
               key_in   = prev_key;
               value_in = prev_value;
            end
         end
         lkvc_pkg::OP_INSERT: begin
            valid_in = (CNT_W'(IDX) < limit);
            key_in   = prev_key;
            value_in = prev_value;
         end
         lkvc_pkg::OP_REMOVE: begin
            if (shift) begin
               valid_in = next_valid;
               key_in   = next_key;
               value_in = next_value;
            end
         end
      endcase
      match_in = cmd.probe ? (valid_ff && (key_ff == probe_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign valid     = valid_ff;
   assign key       = key_ff;
   assign value     = value_ff;
   assign match     = match_ff;
   assign above_out = shift;
   assign sel_value = match_ff ? value_ff : '0;

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache: request control, cell chain, counters.
`default_nettype none

// Fully associative key-value cache kept as a chain of ENTRIES cells ordered
// by recency: cell 0 holds the most recent entry and valid entries always fill
// the front of the chain. At the accepting edge every cell compares its key
// against the request; in the update state the cells shift toward or away
// from the front in one step (touch, insert with eviction of the tail, or
// remove). The result sits in an output register; if it is not yet taken,
// the update state waits until the register frees. The request channel takes
// a new beat while a result beat waits. No clearing pass follows reset. The
// user must write the capacity register (csr_we, csr_wdata) only while the
// cache is idle, unenforced by the block; values above ENTRIES act as ENTRIES.
module lru_key_value_cache_top #(
   parameter int ENTRIES    = 64,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   lkvc_req_if.sink                     req_bus,
   lkvc_rsp_if.source                   rsp_bus,
   input  wire                          csr_we,
   input  wire  [lkvc_pkg::CAP_W-1:0]   csr_wdata
);

`include "lru_key_value_cache_top_macros.svh"

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic [lkvc_pkg::CAP_W-1:0]       cap_ff, cap_in;
   logic [CNT_W-1:0]                 held_ff, held_in;
   logic [lkvc_pkg::COUNT_W-1:0]     hit_ff, hit_in;
   logic [lkvc_pkg::COUNT_W-1:0]     miss_ff, miss_in;
   logic [lkvc_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [KEY_BITS-1:0]              key_ff, key_in;
   logic [VALUE_BITS-1:0]            wval_ff, wval_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic [lkvc_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [lkvc_pkg::COUNT_W-1:0]     rsp_hit_ff, rsp_hit_in;
   logic [lkvc_pkg::COUNT_W-1:0]     rsp_miss_ff, rsp_miss_in;
   logic [lkvc_pkg::ITEM_W-1:0]      rsp_items_ff, rsp_items_in;

   logic                             accept;
   logic                             commit;
   logic                             hit;
   logic [VALUE_BITS-1:0]            hit_value;
   logic [VALUE_BITS-1:0]            front_value;
   lkvc_pkg::cell_cmd_type           cmd;
   logic [CNT_W-1:0]                 limit;
   logic [CMP_W-1:0]                 cap_w, eff_w, held_w, limit_w;

   logic [ENTRIES-1:0]               valid_vec;
   logic [ENTRIES-1:0]               match_vec;
   logic [ENTRIES:0]                 above;
   logic [KEY_BITS-1:0]              cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0]            cell_value [ENTRIES];
   logic [VALUE_BITS-1:0]            cell_sel   [ENTRIES];

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign commit        = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | cell_sel[i];
      end
      hit         = |match_vec;
      front_value = (mode_ff == lkvc_pkg::MODE_PUT) ? wval_ff : hit_value;
   end

   always_comb begin
      cap_w   = CMP_W'(cap_ff);
      eff_w   = (cap_w > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_w;
      held_w  = CMP_W'(held_ff);
      if (eff_w == '0) begin
         limit_w = '0;
      end else if (held_w >= eff_w) begin
         limit_w = eff_w;
      end else begin
         limit_w = held_w + 1'b1;
      end
      limit = CNT_W'(limit_w);
   end

   always_comb begin
      cmd.probe     = accept;
      cmd.op        = lkvc_pkg::OP_HOLD;
      held_in       = held_ff;
      hit_in        = hit_ff;
      miss_in       = miss_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_items_in  = rsp_items_ff;
      if (commit) begin
         rsp_status_in = 1'b0;
         rsp_value_in  = '0;
         unique case (mode_ff)
            lkvc_pkg::MODE_GET: begin
               if (hit) begin
                  cmd.op       = lkvc_pkg::OP_TOUCH;
                  rsp_value_in = lkvc_pkg::VALUE_W'(hit_value);
                  hit_in       = hit_ff + lkvc_pkg::COUNT_W'(hit_ff != '1);
               end else begin
                  rsp_status_in = 1'b1;
                  miss_in       = miss_ff + lkvc_pkg::COUNT_W'(miss_ff != '1);
               end
            end
            lkvc_pkg::MODE_PUT: begin
               if (hit) begin
                  cmd.op = lkvc_pkg::OP_TOUCH;
               end else begin
                  cmd.op  = lkvc_pkg::OP_INSERT;
                  held_in = limit;
               end
            end
            lkvc_pkg::MODE_DELETE: begin
               if (hit) begin
                  cmd.op  = lkvc_pkg::OP_REMOVE;
                  held_in = held_ff - 1'b1;
               end else begin
                  rsp_status_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rsp_hit_in   = hit_in;
         rsp_miss_in  = miss_in;
         rsp_items_in = lkvc_pkg::ITEM_W'(held_in);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_UPDATE;
         S_UPDATE: if (commit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
      cap_in       = csr_we ? csr_wdata : cap_ff;
      mode_in      = accept ? req_bus.mode : mode_ff;
      key_in       = accept ? req_bus.key[KEY_BITS-1:0] : key_ff;
      wval_in      = accept ? req_bus.write_value[VALUE_BITS-1:0] : wval_ff;
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         held_ff      <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         held_ff      <= held_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_items_ff  <= rsp_items_in;
   end

   assign above[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic                  pv, nv;
      logic [KEY_BITS-1:0]   pk, nk;
      logic [VALUE_BITS-1:0] pval, nval;

      if (i == 0) begin : g_front
         assign pv   = 1'b1;
         assign pk   = key_ff;
         assign pval = front_value;
      end else begin : g_prev
         assign pv   = valid_vec[i-1];
         assign pk   = cell_key[i-1];
         assign pval = cell_value[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign nv   = 1'b0;
         assign nk   = '0;
         assign nval = '0;
      end else begin : g_next
         assign nv   = valid_vec[i+1];
         assign nk   = cell_key[i+1];
         assign nval = cell_value[i+1];
      end

      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .CNT_W      (CNT_W),
         .IDX        (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .probe_key  (req_bus.key[KEY_BITS-1:0]),
         .limit      (limit),
         .above_in   (above[i]),
         .prev_valid (pv),
         .prev_key   (pk),
         .prev_value (pval),
         .next_valid (nv),
         .next_key   (nk),
         .next_value (nval),
         .valid      (valid_vec[i]),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .match      (match_vec[i]),
         .above_out  (above[i+1]),
         .sel_value  (cell_sel[i])
      );
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_value_ff;
   assign rsp_bus.hit_count  = rsp_hit_ff;
   assign rsp_bus.miss_count = rsp_miss_ff;
   assign rsp_bus.item_count = rsp_items_ff;

   `LKVC_ASSERT_IMPLIES(a_match_unique, clock, reset, state_ff == S_UPDATE, $onehot0(match_vec))
   `LKVC_ASSERT_IMPLIES(a_held_count, clock, reset, 1'b1, $countones(valid_vec) == int'(held_ff))
   `LKVC_ASSERT_IMPLIES(a_held_bound, clock, reset, 1'b1, held_ff <= CNT_W'(ENTRIES))
   `LKVC_ASSERT_NEXT(a_commit_shows, clock, reset, commit, rsp_valid_ff)
   `LKVC_ASSERT_NEXT(a_accept_updates, clock, reset, accept, state_ff == S_UPDATE)

endmodule

`default_nettype wire
